/* src/bawl_pkg.sv */
// Shared types, codes and defaults for the block allocator with LRU aging.
package bawl_pkg;

    localparam int TABLE_SIZE_DEF   = 64;
    localparam int BLOCK_BYTES_DEF  = 65536;
    localparam int BASE_ADDRESS_DEF = 256 * 1024;
    localparam int HANDLE_BITS_DEF  = 16;

    localparam logic [15:0] AGE_MAX = 16'hFFFF;

    typedef enum logic [1:0] {
        OP_ALLOC = 2'd0,
        OP_FREE  = 2'd1,
        OP_TOUCH = 2'd2,
        OP_QUERY = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        STAT_OK        = 2'd0,
        STAT_NO_ROOM   = 2'd1,
        STAT_NOT_FOUND = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_STATS,
        ST_WORK,
        ST_MARK,
        ST_ADDR,
        ST_OUT
    } state_t;

    typedef struct packed {
        op_t         opcode;
        logic [15:0] handle;
        logic [7:0]  owner_id;
        logic [6:0]  block_count;
    } in_t;

    typedef struct packed {
        status_t     status;
        logic [5:0]  block_index;
        logic [22:0] block_address;
        logic [15:0] handle_out;
        logic [6:0]  free_blocks;
        logic [6:0]  largest_free_run;
    } out_t;

    typedef struct packed {
        logic [15:0] handle;
        logic [7:0]  owner;
        logic [15:0] age;
    } entry_t;

endpackage

/* src/block_allocator_with_lru.sv */
// Block allocator with first-fit runs, owner-bounded free, LRU aging and oldest query.
//
// A table of TABLE_SIZE fixed-size blocks; each entry has a valid bit (flip-flops,
// cleared by reset) and a handle/owner/age word held in a single-port-write,
// single-port-read memory that needs no clearing: handle and owner are only looked
// at on valid entries, and allocation zeroes the age it writes. The table is usable
// in the first cycle after reset. One transaction is worked at a time and s_ready
// is high only while the sequencer is idle. Every operation first walks the valid
// bits, one entry per cycle, to get the free count, the longest free run and, for
// allocation, the first-fit run. A placed allocation then writes its run, one entry
// per cycle. Free, touch and query instead stream the whole entry memory through
// one compare/update unit, one entry per cycle, read through a registered port.
// The block address (base plus index times block size) is then formed and
// registered, after which the result register is loaded. The result register
// holds a finished transaction until m_ready takes it; the next operation may run
// meanwhile and waits only if its own result is ready before the previous one has
// been taken.
module block_allocator_with_lru #(
    parameter int TABLE_SIZE   = bawl_pkg::TABLE_SIZE_DEF,
    parameter int BLOCK_BYTES  = bawl_pkg::BLOCK_BYTES_DEF,
    parameter int BASE_ADDRESS = bawl_pkg::BASE_ADDRESS_DEF,
    parameter int HANDLE_BITS  = bawl_pkg::HANDLE_BITS_DEF
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    input  bawl_pkg::in_t  s_payload,
    output logic           m_valid,
    input  logic           m_ready,
    output bawl_pkg::out_t m_payload
);

    localparam int IW   = (TABLE_SIZE > 1) ? $clog2(TABLE_SIZE) : 1;
    localparam int CW   = $clog2(TABLE_SIZE + 1);
    localparam int CMPW = ((CW > 7) ? CW : 7) + 1;

    localparam logic [15:0] HMASK = (HANDLE_BITS >= 16) ? 16'hFFFF
                                  : 16'((32'd1 << HANDLE_BITS) - 32'd1);
    localparam logic [22:0] BASE23  = 23'(BASE_ADDRESS);
    localparam logic [22:0] BLOCK23 = 23'(BLOCK_BYTES);

    // Sequencer and request
    bawl_pkg::state_t state_reg, state_next;
    bawl_pkg::in_t    req_reg, req_next;

    // Table state
    logic [TABLE_SIZE-1:0] valid_reg, valid_next;
    logic [CW-1:0]         used_reg, used_next;
    bawl_pkg::entry_t      mem [TABLE_SIZE];

    // Valid-bit walk: statistics and first-fit search
    logic [IW-1:0] scan_idx_reg, scan_idx_next;
    logic [CW-1:0] freec_reg, freec_next;
    logic [CW-1:0] run_reg, run_next;
    logic [CW-1:0] best_reg, best_next;
    logic [CW-1:0] len_reg, len_next;
    logic [IW-1:0] start_reg, start_next;
    logic          run_found_reg, run_found_next;

    // Memory stream
    logic [IW:0]      work_cnt_reg, work_cnt_next;
    logic             p_valid_reg, p_valid_next;
    logic [IW-1:0]    p_idx_reg, p_idx_next;
    bawl_pkg::entry_t rd_data_reg;
    logic             rd_en;
    logic [IW-1:0]    rd_addr;
    logic             mem_we;
    logic [IW-1:0]    mem_waddr;
    bawl_pkg::entry_t mem_wdata;

    // Per-operation result tracking
    logic          found_reg, found_next;
    logic          stop_reg, stop_next;
    logic [7:0]    tag_reg, tag_next;
    logic [6:0]    done_reg, done_next;
    logic [15:0]   oldest_reg, oldest_next;
    logic [IW-1:0] res_idx_reg, res_idx_next;
    logic [15:0]   hout_reg, hout_next;
    logic [6:0]    mcnt_reg, mcnt_next;
    logic [22:0]   addr_reg, addr_next;
    logic [IW-1:0] idx_sel;

    // Result register
    logic           m_valid_reg, m_valid_next;
    bawl_pkg::out_t m_payload_reg, m_payload_next;

    logic          scan_last;
    logic          alloc_en;
    logic          scan_v;
    logic          proc_v;
    logic          out_load;
    logic [CW-1:0] run_step;
    logic [CW-1:0] len_step;

    assign s_ready   = (state_reg == bawl_pkg::ST_IDLE);
    assign m_valid   = m_valid_reg;
    assign m_payload = m_payload_reg;

    assign scan_last = (scan_idx_reg == IW'(TABLE_SIZE - 1));
    assign scan_v    = valid_reg[scan_idx_reg];
    assign proc_v    = valid_reg[p_idx_reg];
    assign alloc_en  = (req_reg.block_count != 7'd0)
                    && ((CMPW'(used_reg) + CMPW'(req_reg.block_count)) <= CMPW'(TABLE_SIZE));
    assign rd_en     = (state_reg == bawl_pkg::ST_WORK) && (work_cnt_reg < (IW+1)'(TABLE_SIZE));
    assign rd_addr   = work_cnt_reg[IW-1:0];
    assign out_load  = (state_reg == bawl_pkg::ST_OUT) && (!m_valid_reg || m_ready);
    assign idx_sel   = (req_reg.opcode == bawl_pkg::OP_ALLOC) ? start_reg : res_idx_reg;

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            bawl_pkg::ST_IDLE: begin
                if (s_valid) state_next = bawl_pkg::ST_STATS;
            end
            bawl_pkg::ST_STATS: begin
                if (scan_last) begin
                    state_next = (req_reg.opcode == bawl_pkg::OP_ALLOC) ? bawl_pkg::ST_MARK
                                                                        : bawl_pkg::ST_WORK;
                end
            end
            bawl_pkg::ST_WORK: begin
                if (work_cnt_reg == (IW+1)'(TABLE_SIZE)) state_next = bawl_pkg::ST_ADDR;
            end
            bawl_pkg::ST_MARK: begin
                if (!run_found_reg || mcnt_reg == req_reg.block_count) begin
                    state_next = bawl_pkg::ST_ADDR;
                end
            end
            bawl_pkg::ST_ADDR: state_next = bawl_pkg::ST_OUT;
            bawl_pkg::ST_OUT: begin
                if (out_load) state_next = bawl_pkg::ST_IDLE;
            end
            default: state_next = bawl_pkg::ST_IDLE;
        endcase
    end

    // Datapath
    always_comb begin
        req_next       = req_reg;
        valid_next     = valid_reg;
        used_next      = used_reg;
        scan_idx_next  = scan_idx_reg;
        freec_next     = freec_reg;
        run_next       = run_reg;
        best_next      = best_reg;
        len_next       = len_reg;
        start_next     = start_reg;
        run_found_next = run_found_reg;
        work_cnt_next  = work_cnt_reg;
        p_valid_next   = 1'b0;
        p_idx_next     = p_idx_reg;
        found_next     = found_reg;
        stop_next      = stop_reg;
        tag_next       = tag_reg;
        done_next      = done_reg;
        oldest_next    = oldest_reg;
        res_idx_next   = res_idx_reg;
        hout_next      = hout_reg;
        mcnt_next      = mcnt_reg;
        addr_next      = addr_reg;
        mem_we         = 1'b0;
        mem_waddr      = p_idx_reg;
        mem_wdata      = rd_data_reg;
        m_valid_next   = m_valid_reg && !m_ready;
        m_payload_next = m_payload_reg;
        run_step       = run_reg + CW'(1);
        len_step       = len_reg + CW'(1);

        // Take a new transaction and clear the per-operation trackers
        if (state_reg == bawl_pkg::ST_IDLE && s_valid) begin
            req_next        = s_payload;
            req_next.handle = s_payload.handle & HMASK;
            scan_idx_next   = '0;
            freec_next      = '0;
            run_next        = '0;
            best_next       = '0;
            len_next        = '0;
            start_next      = '0;
            run_found_next  = 1'b0;
            work_cnt_next   = '0;
            found_next      = 1'b0;
            stop_next       = 1'b0;
            tag_next        = '0;
            done_next       = '0;
            oldest_next     = '0;
            res_idx_next    = '0;
            hout_next       = '0;
            mcnt_next       = '0;
        end

        // Walk the valid bits: free count, longest run, first-fit run
        if (state_reg == bawl_pkg::ST_STATS) begin
            scan_idx_next = scan_idx_reg + IW'(1);
            if (!scan_v) begin
                freec_next = freec_reg + CW'(1);
                run_next   = run_step;
                if (run_step > best_reg) best_next = run_step;
            end else begin
                run_next = '0;
            end
            if (alloc_en && !run_found_reg) begin
                if (!scan_v) begin
                    if (len_reg == '0) start_next = scan_idx_reg;
                    len_next = len_step;
                    if (CMPW'(len_step) >= CMPW'(req_reg.block_count)) run_found_next = 1'b1;
                end else begin
                    len_next = '0;
                end
            end
        end

        // Write the allocated run, one entry per cycle
        if (state_reg == bawl_pkg::ST_MARK && run_found_reg
                && mcnt_reg != req_reg.block_count) begin
            mem_we                = 1'b1;
            mem_waddr             = start_reg + IW'(mcnt_reg);
            mem_wdata.handle      = req_reg.handle;
            mem_wdata.owner       = req_reg.owner_id;
            mem_wdata.age         = '0;
            valid_next[mem_waddr] = 1'b1;
            used_next             = used_reg + CW'(1);
            mcnt_next             = mcnt_reg + 7'd1;
        end

        // Stream the entry memory through the compare/update unit
        if (rd_en) begin
            p_valid_next  = 1'b1;
            p_idx_next    = rd_addr;
            work_cnt_next = work_cnt_reg + (IW+1)'(1);
        end

        if (state_reg == bawl_pkg::ST_WORK && p_valid_reg) begin
            unique case (req_reg.opcode)
                bawl_pkg::OP_FREE: begin
                    if (!found_reg) begin
                        if (proc_v && rd_data_reg.handle == req_reg.handle) begin
                            found_next   = 1'b1;
                            res_idx_next = p_idx_reg;
                            tag_next     = rd_data_reg.owner;
                            if (req_reg.block_count != 7'd0) begin
                                valid_next[p_idx_reg] = 1'b0;
                                if (used_reg != '0) used_next = used_reg - CW'(1);
                                done_next = 7'd1;
                            end
                        end
                    end else if (!stop_reg) begin
                        if (done_reg < req_reg.block_count && proc_v
                                && rd_data_reg.owner == tag_reg) begin
                            valid_next[p_idx_reg] = 1'b0;
                            if (used_reg != '0) used_next = used_reg - CW'(1);
                            done_next = done_reg + 7'd1;
                        end else begin
                            stop_next = 1'b1;
                        end
                    end
                end
                bawl_pkg::OP_TOUCH: begin
                    mem_we = 1'b1;
                    if (proc_v && rd_data_reg.handle == req_reg.handle) begin
                        mem_wdata.age = '0;
                        found_next    = 1'b1;
                    end else if (rd_data_reg.age != bawl_pkg::AGE_MAX) begin
                        mem_wdata.age = rd_data_reg.age + 16'd1;
                    end
                end
                bawl_pkg::OP_QUERY: begin
                    if (proc_v && rd_data_reg.owner == req_reg.owner_id
                            && (!found_reg || rd_data_reg.age >= oldest_reg)) begin
                        found_next   = 1'b1;
                        oldest_next  = rd_data_reg.age;
                        res_idx_next = p_idx_reg;
                        hout_next    = rd_data_reg.handle;
                    end
                end
                default: begin
                end
            endcase
        end

        // Form the block address
        if (state_reg == bawl_pkg::ST_ADDR) begin
            addr_next = BASE23 + 23'(23'(idx_sel) * BLOCK23);
        end

        // Load the result register
        if (out_load) begin
            m_valid_next                    = 1'b1;
            m_payload_next.free_blocks      = 7'(freec_reg);
            m_payload_next.largest_free_run = 7'(best_reg);
            m_payload_next.handle_out       = '0;
            m_payload_next.block_index      = '0;
            m_payload_next.block_address    = '0;
            unique case (req_reg.opcode)
                bawl_pkg::OP_ALLOC: begin
                    m_payload_next.status = run_found_reg ? bawl_pkg::STAT_OK
                                                          : bawl_pkg::STAT_NO_ROOM;
                    if (run_found_reg) begin
                        m_payload_next.block_index   = 6'(idx_sel);
                        m_payload_next.block_address = addr_reg;
                    end
                end
                bawl_pkg::OP_TOUCH: begin
                    m_payload_next.status = found_reg ? bawl_pkg::STAT_OK
                                                      : bawl_pkg::STAT_NOT_FOUND;
                end
                bawl_pkg::OP_FREE, bawl_pkg::OP_QUERY: begin
                    m_payload_next.status = found_reg ? bawl_pkg::STAT_OK
                                                      : bawl_pkg::STAT_NOT_FOUND;
                    if (found_reg) begin
                        m_payload_next.block_index   = 6'(idx_sel);
                        m_payload_next.block_address = addr_reg;
                        if (req_reg.opcode == bawl_pkg::OP_QUERY) begin
                            m_payload_next.handle_out = hout_reg;
                        end
                    end
                end
                default: begin
                    m_payload_next.status = bawl_pkg::STAT_NOT_FOUND;
                end
            endcase
        end
    end

    // Entry memory: one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (mem_we) mem[mem_waddr] <= mem_wdata;
        if (rd_en) rd_data_reg <= mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= bawl_pkg::ST_IDLE;
            valid_reg   <= '0;
            used_reg    <= '0;
            p_valid_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            valid_reg   <= valid_next;
            used_reg    <= used_next;
            p_valid_reg <= p_valid_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        req_reg       <= req_next;
        scan_idx_reg  <= scan_idx_next;
        freec_reg     <= freec_next;
        run_reg       <= run_next;
        best_reg      <= best_next;
        len_reg       <= len_next;
        start_reg     <= start_next;
        run_found_reg <= run_found_next;
        work_cnt_reg  <= work_cnt_next;
        p_idx_reg     <= p_idx_next;
        found_reg     <= found_next;
        stop_reg      <= stop_next;
        tag_reg       <= tag_next;
        done_reg      <= done_next;
        oldest_reg    <= oldest_next;
        res_idx_reg   <= res_idx_next;
        hout_reg      <= hout_next;
        mcnt_reg      <= mcnt_next;
        addr_reg      <= addr_next;
        m_payload_reg <= m_payload_next;
    end

    // The used count tracks the valid bits whenever the sequencer rests
    a_used_matches_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == bawl_pkg::ST_IDLE |-> $countones(valid_reg) == int'(used_reg))
        else $error("used count out of step with valid bits");

    // An accepted transaction always starts with the valid-bit walk
    a_accept_starts_walk: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> state_reg == bawl_pkg::ST_STATS)
        else $error("accepted transaction did not start the walk");

    // A refused allocation reports neither index nor address
    a_no_room_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_payload.status == bawl_pkg::STAT_NO_ROOM)
            |-> (m_payload.block_address == 23'd0 && m_payload.block_index == 6'd0))
        else $error("refused allocation carries an address");

    // A result appears only from the output load step
    a_result_from_out: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(state_reg) == bawl_pkg::ST_OUT)
        else $error("result raised outside the output step");

endmodule
